FILE: design/lpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar projection package
// Shared widths, codes and item types of the lidar point projection core.
// ----------------------------------------------------------------------------
package lpp_pkg;

	localparam int COORD_W    = 20;
	localparam int COEF_W     = 16;
	localparam int CAM_W      = 26;
	localparam int SQ_W       = 2 * CAM_W;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int RANGE_W    = 20;
	localparam int NUM_W      = 42;
	localparam int DEN_W      = CAM_W - 1;
	localparam int INTR_W     = 16;
	localparam int DIM_MAX    = 16;
	localparam int IDX_W      = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	localparam int DIV_LAT  = NUM_W;
	localparam int SQRT_LAT = ROOT_W;

	localparam int MID_DEPTH = 8;
	localparam int MID_CNT_W = $clog2(MID_DEPTH) + 1;
	localparam int OUT_DEPTH = 64;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

	typedef enum logic [2:0] {
		RSN_KEPT    = 3'd0,
		RSN_FORWARD = 3'd1,
		RSN_CLOSE   = 3'd2,
		RSN_DEPTH   = 3'd3,
		RSN_OUTSIDE = 3'd4
	} reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0       = 4'd0,
		CFG_ROW1       = 4'd1,
		CFG_ROW2       = 4'd2,
		CFG_INTRINSICS = 4'd3,
		CFG_WIDTH      = 4'd4,
		CFG_HEIGHT     = 4'd5,
		CFG_MIN_FWD    = 4'd6,
		CFG_MIN_RANGE  = 4'd7
	} cfg_idx_t;

	// Classified point handed from the front end to the projection back end.
	typedef struct packed {
		logic signed [CAM_W-1:0] c0;
		logic signed [CAM_W-1:0] c1;
		logic signed [CAM_W-1:0] c2;
		logic [SQ_W-1:0]         sumsq;
		logic                    fwd_fail;
		logic                    eoc;
	} mid_item_t;

	typedef struct packed {
		logic                 accepted;
		reason_t              reason;
		logic [DIM_MAX-1:0]   col;
		logic [DIM_MAX-1:0]   row;
		logic [IDX_W-1:0]     idx;
		logic [RANGE_W-1:0]   range;
		logic                 eoc;
	} res_item_t;

endpackage

FILE: design/lpp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar projection queue
// Memory queue with a registered head entry and an occupancy count.
// ----------------------------------------------------------------------------
module lpp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               din,
	input  logic                       pop,
	output logic [W-1:0]               dout,
	output logic                       dvalid,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   mcnt_q;
	logic          ov_q;
	logic [W-1:0]  dout_q;
	logic          load;

	// The head register refills from memory whenever it is free or being taken.
	assign load = (mcnt_q != '0) && (!ov_q || pop);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
		if (load) begin
			dout_q <= mem_q[rptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			mcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (load) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, load})
				2'b10:   mcnt_q <= mcnt_q + 1'b1;
				2'b01:   mcnt_q <= mcnt_q - 1'b1;
				default: mcnt_q <= mcnt_q;
			endcase
			if (load) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign dout   = dout_q;
	assign dvalid = ov_q;
	assign count  = mcnt_q + (AW + 1)'(ov_q);

endmodule

FILE: design/lpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar projection front end
// Extrinsic transform, squared range and forward-limit check in four stages.
// ----------------------------------------------------------------------------
module lpp_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [lpp_pkg::COORD_W-1:0]    point_x,
	input  logic signed [lpp_pkg::COORD_W-1:0]    point_y,
	input  logic signed [lpp_pkg::COORD_W-1:0]    point_z,
	input  logic                                  end_of_cloud,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]        row0,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]        row1,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]        row2,
	input  logic signed [lpp_pkg::COORD_W-1:0]    min_forward,
	input  logic [lpp_pkg::MID_CNT_W-1:0]         queue_count,
	output logic                                  item_valid,
	output lpp_pkg::mid_item_t                    item
);

	localparam int PROD_W = lpp_pkg::COEF_W + lpp_pkg::COORD_W;
	localparam int BIAS_W = lpp_pkg::COEF_W + 8;
	localparam int ACC_W  = PROD_W + 2;
	localparam int CAM_W  = lpp_pkg::CAM_W;
	localparam int SQ_W   = lpp_pkg::SQ_W;
	localparam int CW     = lpp_pkg::COEF_W;

	logic [lpp_pkg::CFG_DATA_W-1:0]     rows [3];
	logic signed [lpp_pkg::COORD_W-1:0] pts [3];

	logic signed [PROD_W-1:0] prod_n [3][3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [BIAS_W-1:0] bias_n [3];
	logic signed [BIAS_W-1:0] bias_s1 [3];
	logic signed [ACC_W-1:0]  acc_n [3];
	logic signed [CAM_W-1:0]  c_s2 [3];
	logic signed [CAM_W-1:0]  c_s3 [3];
	logic signed [CAM_W-1:0]  c_s4 [3];
	logic [CAM_W-1:0]         mag_n [3];
	logic [SQ_W-1:0]          sq_n [3];
	logic [SQ_W-1:0]          sq_s3 [3];
	logic [SQ_W-1:0]          sumsq_s4;

	logic v_s1, v_s2, v_s3, v_s4;
	logic fwd_s1, fwd_s2, fwd_s3, fwd_s4;
	logic eoc_s1, eoc_s2, eoc_s3, eoc_s4;
	logic accept;
	logic [lpp_pkg::MID_CNT_W:0] occ;

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;
	assign pts[0]  = point_x;
	assign pts[1]  = point_y;
	assign pts[2]  = point_z;

	// Every item in flight here already owns a slot in the queue behind.
	assign occ = (lpp_pkg::MID_CNT_W + 1)'(queue_count)
		+ (lpp_pkg::MID_CNT_W + 1)'(v_s1) + (lpp_pkg::MID_CNT_W + 1)'(v_s2)
		+ (lpp_pkg::MID_CNT_W + 1)'(v_s3) + (lpp_pkg::MID_CNT_W + 1)'(v_s4);
	assign full   = occ >= (lpp_pkg::MID_CNT_W + 1)'(lpp_pkg::MID_DEPTH);
	assign accept = push && !full;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				prod_n[r][k] = $signed(rows[r][k*CW +: CW]) * pts[k];
			end
			bias_n[r] = $signed({rows[r][3*CW +: CW], 8'd0});
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_n[r] = ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1])
				+ ACC_W'(prod_s1[r][2]) + ACC_W'(bias_s1[r]);
			mag_n[r] = c_s2[r][CAM_W-1] ? CAM_W'(-c_s2[r]) : CAM_W'(c_s2[r]);
			sq_n[r]  = mag_n[r] * mag_n[r];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_n;
		bias_s1 <= bias_n;
		fwd_s1  <= point_x < min_forward;
		eoc_s1  <= end_of_cloud;
		for (int r = 0; r < 3; r++) begin
			c_s2[r] <= CAM_W'(acc_n[r] >>> 12);
		end
		fwd_s2   <= fwd_s1;
		eoc_s2   <= eoc_s1;
		c_s3     <= c_s2;
		sq_s3    <= sq_n;
		fwd_s3   <= fwd_s2;
		eoc_s3   <= eoc_s2;
		c_s4     <= c_s3;
		sumsq_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		fwd_s4   <= fwd_s3;
		eoc_s4   <= eoc_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign item_valid     = v_s4;
	assign item.c0        = c_s4[0];
	assign item.c1        = c_s4[1];
	assign item.c2        = c_s4[2];
	assign item.sumsq     = sumsq_s4;
	assign item.fwd_fail  = fwd_s4;
	assign item.eoc       = eoc_s4;

endmodule

FILE: design/lpp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar projection divider
// Pipelined restoring divider, one quotient bit per stage, floored result.
// ----------------------------------------------------------------------------
module lpp_div #(
	parameter int NW = 42,
	parameter int DW = 25
) (
	input  logic                 clk,
	input  logic signed [NW:0]   num,
	input  logic [DW-1:0]        den,
	output logic signed [NW:0]   quo
);

	logic [NW-1:0] rq_s  [0:NW];
	logic [DW-1:0] rem_s [0:NW];
	logic [DW-1:0] den_s [0:NW];
	logic          neg_s [0:NW];
	logic [NW:0]   qa;

	assign neg_s[0] = num[NW];
	assign rq_s[0]  = num[NW] ? NW'(-num) : NW'(num);
	assign rem_s[0] = '0;
	assign den_s[0] = den;

	for (genvar i = 1; i <= NW; i++) begin : g_stage
		logic [DW:0] t;
		assign t = {rem_s[i-1], rq_s[i-1][NW-1]};
		always_ff @(posedge clk) begin
			if (t >= {1'b0, den_s[i-1]}) begin
				rem_s[i] <= DW'(t - {1'b0, den_s[i-1]});
				rq_s[i]  <= {rq_s[i-1][NW-2:0], 1'b1};
			end else begin
				rem_s[i] <= t[DW-1:0];
				rq_s[i]  <= {rq_s[i-1][NW-2:0], 1'b0};
			end
			den_s[i] <= den_s[i-1];
			neg_s[i] <= neg_s[i-1];
		end
	end

	// A negative dividend with a remainder rounds one further down.
	assign qa  = {1'b0, rq_s[NW]} + (NW + 1)'(neg_s[NW] && (rem_s[NW] != '0));
	assign quo = neg_s[NW] ? $signed(-qa) : $signed(qa);

endmodule

FILE: design/lpp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar projection square root
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lpp_isqrt #(
	parameter int RW = 52
) (
	input  logic                clk,
	input  logic [RW-1:0]       rad,
	output logic [RW/2-1:0]     root
);

	localparam int ST    = RW / 2;
	localparam int REM_W = ST + 2;

	logic [RW-1:0]    rad_s  [0:ST];
	logic [ST-1:0]    root_s [0:ST];
	logic [REM_W-1:0] rem_s  [0:ST];

	assign rad_s[0]  = rad;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;

	for (genvar i = 1; i <= ST; i++) begin : g_stage
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] cmp;
		assign trial = {rem_s[i-1], rad_s[i-1][RW-1 -: 2]};
		assign cmp   = (REM_W + 2)'({root_s[i-1], 2'b01});
		always_ff @(posedge clk) begin
			if (trial >= cmp) begin
				rem_s[i]  <= REM_W'(trial - cmp);
				root_s[i] <= {root_s[i-1][ST-2:0], 1'b1};
			end else begin
				rem_s[i]  <= REM_W'(trial);
				root_s[i] <= {root_s[i-1][ST-2:0], 1'b0};
			end
			rad_s[i] <= rad_s[i-1] << 2;
		end
	end

	assign root = root_s[ST];

endmodule

FILE: design/lpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar projection back end
// Perspective divide, range root, bounds check and pixel index.
// ----------------------------------------------------------------------------
module lpp_back #(
	parameter int DIM_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  lpp_pkg::mid_item_t                 item,
	output logic                               item_pop,
	input  logic [lpp_pkg::OUT_CNT_W-1:0]      out_count,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]     intrinsics,
	input  logic [DIM_BITS-1:0]                image_width,
	input  logic [DIM_BITS-1:0]                image_height,
	input  logic [lpp_pkg::RANGE_W-1:0]        min_range,
	output logic                               res_valid,
	output lpp_pkg::res_item_t                 res
);

	localparam int NUM_W   = lpp_pkg::NUM_W;
	localparam int DEN_W   = lpp_pkg::DEN_W;
	localparam int IW      = lpp_pkg::INTR_W;
	localparam int DLAT    = lpp_pkg::DIV_LAT;
	localparam int RDLY    = lpp_pkg::DIV_LAT - lpp_pkg::SQRT_LAT;
	localparam int ROOT_W  = lpp_pkg::ROOT_W;
	localparam int RANGE_W = lpp_pkg::RANGE_W;
	localparam int PIX_W   = NUM_W + 2;
	localparam int CNT_W   = lpp_pkg::OUT_CNT_W;

	typedef struct packed {
		logic fwd_fail;
		logic c2_pos;
		logic eoc;
	} side_t;

	logic [CNT_W-1:0]   inflight_q;
	logic [CNT_W:0]     held;
	logic               take;

	logic                    v_s1;
	logic signed [NUM_W:0]   nu_s1, nv_s1;
	logic [DEN_W-1:0]        den_s1;
	logic [lpp_pkg::SQ_W-1:0] sumsq_s1;
	side_t                   side_s1;

	logic signed [NUM_W:0]   qu, qv;
	logic [ROOT_W-1:0]       root;
	side_t                   side_d [DLAT];
	logic                    vld_d  [DLAT];
	logic [ROOT_W-1:0]       root_d [RDLY];

	logic [PIX_W-1:0]        u, v;
	logic [PIX_W-5:0]        colw, roww;
	logic                    in_frame;
	logic [RANGE_W-1:0]      range_n;
	lpp_pkg::reason_t        rsn_n;

	logic                    v_s2;
	lpp_pkg::reason_t        rsn_s2;
	logic [DIM_BITS-1:0]     col_s2, row_s2;
	logic [RANGE_W-1:0]      range_s2;
	logic                    eoc_s2;
	logic [2*DIM_BITS-1:0]   rw_n;

	logic                    v_s3;
	lpp_pkg::res_item_t      res_s3;

	// Each item taken here owns a slot in the result queue until it lands there.
	assign held = (CNT_W + 1)'(inflight_q) + (CNT_W + 1)'(out_count);
	assign take = item_valid && (held < (CNT_W + 1)'(lpp_pkg::OUT_DEPTH));
	assign item_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({take, v_s3})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		nu_s1  <= $signed({1'b0, intrinsics[0*IW +: IW]}) * item.c0;
		nv_s1  <= $signed({1'b0, intrinsics[1*IW +: IW]}) * item.c1;
		den_s1 <= item.c2[DEN_W-1:0];
		sumsq_s1         <= item.sumsq;
		side_s1.fwd_fail <= item.fwd_fail;
		side_s1.c2_pos   <= !item.c2[lpp_pkg::CAM_W-1] && (item.c2 != '0);
		side_s1.eoc      <= item.eoc;
	end

	lpp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_col (
		.clk (clk),
		.num (nu_s1),
		.den (den_s1),
		.quo (qu)
	);

	lpp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_row (
		.clk (clk),
		.num (nv_s1),
		.den (den_s1),
		.quo (qv)
	);

	lpp_isqrt #(.RW(lpp_pkg::SQ_W)) u_isqrt (
		.clk  (clk),
		.rad  (sumsq_s1),
		.root (root)
	);

	// Side data and the early root travel alongside the dividers.
	always_ff @(posedge clk) begin
		side_d[0] <= side_s1;
		for (int i = 1; i < DLAT; i++) begin
			side_d[i] <= side_d[i-1];
		end
		root_d[0] <= root;
		for (int i = 1; i < RDLY; i++) begin
			root_d[i] <= root_d[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < DLAT; i++) begin
				vld_d[i] <= 1'b0;
			end
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1     <= take;
			vld_d[0] <= v_s1;
			for (int i = 1; i < DLAT; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
			v_s2 <= vld_d[DLAT-1];
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		u    = PIX_W'(qu) + PIX_W'(intrinsics[2*IW +: IW]);
		v    = PIX_W'(qv) + PIX_W'(intrinsics[3*IW +: IW]);
		colw = u[PIX_W-1:4];
		roww = v[PIX_W-1:4];
		in_frame = !u[PIX_W-1] && !v[PIX_W-1]
			&& (colw < (PIX_W - 4)'(image_width))
			&& (roww < (PIX_W - 4)'(image_height));
		range_n = (root_d[RDLY-1][ROOT_W-1:RANGE_W] != '0) ? '1
			: root_d[RDLY-1][RANGE_W-1:0];
		if (side_d[DLAT-1].fwd_fail) begin
			rsn_n = lpp_pkg::RSN_FORWARD;
		end else if (range_n < min_range) begin
			rsn_n = lpp_pkg::RSN_CLOSE;
		end else if (!side_d[DLAT-1].c2_pos) begin
			rsn_n = lpp_pkg::RSN_DEPTH;
		end else if (!in_frame) begin
			rsn_n = lpp_pkg::RSN_OUTSIDE;
		end else begin
			rsn_n = lpp_pkg::RSN_KEPT;
		end
	end

	always_ff @(posedge clk) begin
		rsn_s2   <= rsn_n;
		col_s2   <= (rsn_n == lpp_pkg::RSN_KEPT) ? colw[DIM_BITS-1:0] : '0;
		row_s2   <= (rsn_n == lpp_pkg::RSN_KEPT) ? roww[DIM_BITS-1:0] : '0;
		range_s2 <= range_n;
		eoc_s2   <= side_d[DLAT-1].eoc;
	end

	assign rw_n = row_s2 * image_width;

	always_ff @(posedge clk) begin
		res_s3.accepted <= rsn_s2 == lpp_pkg::RSN_KEPT;
		res_s3.reason   <= rsn_s2;
		res_s3.col      <= lpp_pkg::DIM_MAX'(col_s2);
		res_s3.row      <= lpp_pkg::DIM_MAX'(row_s2);
		res_s3.idx      <= lpp_pkg::IDX_W'(rw_n + (2 * DIM_BITS)'(col_s2));
		res_s3.range    <= range_s2;
		res_s3.eoc      <= eoc_s2;
	end

	assign res_valid = v_s3;
	assign res       = res_s3;

endmodule

FILE: design/lidar_point_to_pixel_projection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar point to pixel projection core
// Projects lidar points through extrinsic and pinhole intrinsic parameters.
// ----------------------------------------------------------------------------
// A point runs through the front end, the back end with its 42-stage perspective
// dividers and the result queue. Throughput: one point per cycle while full is low.
// Reset clears the queues and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_projection_core #(
	parameter int IMAGE_DIM_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [lpp_pkg::COORD_W-1:0]    point_x,
	input  logic signed [lpp_pkg::COORD_W-1:0]    point_y,
	input  logic signed [lpp_pkg::COORD_W-1:0]    point_z,
	input  logic                                  end_of_cloud,
	output logic                                  empty,
	input  logic                                  pop,
	output logic                                  accepted,
	output logic [2:0]                            reject_reason,
	output logic [IMAGE_DIM_BITS-1:0]             pixel_col,
	output logic [IMAGE_DIM_BITS-1:0]             pixel_row,
	output logic [lpp_pkg::IDX_W-1:0]             pixel_index,
	output logic [lpp_pkg::RANGE_W-1:0]           point_range,
	output logic                                  last_of_cloud,
	input  logic                                  cfg_write,
	input  logic [lpp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int MID_W = $bits(lpp_pkg::mid_item_t);
	localparam int RES_W = $bits(lpp_pkg::res_item_t);

	logic [lpp_pkg::CFG_DATA_W-1:0]     row0_q, row1_q, row2_q, intr_q;
	logic [IMAGE_DIM_BITS-1:0]          width_q, height_q;
	logic signed [lpp_pkg::COORD_W-1:0] min_fwd_q;
	logic [lpp_pkg::RANGE_W-1:0]        min_range_q;

	logic                          f_valid;
	lpp_pkg::mid_item_t            f_item;
	logic [MID_W-1:0]              mid_dout;
	logic                          mid_valid;
	logic [lpp_pkg::MID_CNT_W-1:0] mid_count;
	logic                          mid_pop;

	logic                          b_valid;
	lpp_pkg::res_item_t            b_res;
	logic [RES_W-1:0]              out_dout;
	logic                          out_valid;
	logic [lpp_pkg::OUT_CNT_W-1:0] out_count;
	lpp_pkg::res_item_t            out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q      <= '0;
			row1_q      <= '0;
			row2_q      <= '0;
			intr_q      <= '0;
			width_q     <= IMAGE_DIM_BITS'(1280);
			height_q    <= IMAGE_DIM_BITS'(560);
			min_fwd_q   <= lpp_pkg::COORD_W'(1280);
			min_range_q <= lpp_pkg::RANGE_W'(128);
		end else if (cfg_write) begin
			case (lpp_pkg::cfg_idx_t'(cfg_index))
				lpp_pkg::CFG_ROW0:       row0_q      <= cfg_data;
				lpp_pkg::CFG_ROW1:       row1_q      <= cfg_data;
				lpp_pkg::CFG_ROW2:       row2_q      <= cfg_data;
				lpp_pkg::CFG_INTRINSICS: intr_q      <= cfg_data;
				lpp_pkg::CFG_WIDTH:      width_q     <= cfg_data[IMAGE_DIM_BITS-1:0];
				lpp_pkg::CFG_HEIGHT:     height_q    <= cfg_data[IMAGE_DIM_BITS-1:0];
				lpp_pkg::CFG_MIN_FWD:    min_fwd_q   <= cfg_data[lpp_pkg::COORD_W-1:0];
				lpp_pkg::CFG_MIN_RANGE:  min_range_q <= cfg_data[lpp_pkg::RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	lpp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.end_of_cloud (end_of_cloud),
		.row0         (row0_q),
		.row1         (row1_q),
		.row2         (row2_q),
		.min_forward  (min_fwd_q),
		.queue_count  (mid_count),
		.item_valid   (f_valid),
		.item         (f_item)
	);

	lpp_fifo #(.W(MID_W), .DEPTH(lpp_pkg::MID_DEPTH)) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.din    (f_item),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.dvalid (mid_valid),
		.count  (mid_count)
	);

	lpp_back #(.DIM_BITS(IMAGE_DIM_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (mid_valid),
		.item         (lpp_pkg::mid_item_t'(mid_dout)),
		.item_pop     (mid_pop),
		.out_count    (out_count),
		.intrinsics   (intr_q),
		.image_width  (width_q),
		.image_height (height_q),
		.min_range    (min_range_q),
		.res_valid    (b_valid),
		.res          (b_res)
	);

	lpp_fifo #(.W(RES_W), .DEPTH(lpp_pkg::OUT_DEPTH)) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid),
		.din    (b_res),
		.pop    (pop),
		.dout   (out_dout),
		.dvalid (out_valid),
		.count  (out_count)
	);

	assign out_res       = lpp_pkg::res_item_t'(out_dout);
	assign empty         = !out_valid;
	assign accepted      = out_res.accepted;
	assign reject_reason = out_res.reason;
	assign pixel_col     = out_res.col[IMAGE_DIM_BITS-1:0];
	assign pixel_row     = out_res.row[IMAGE_DIM_BITS-1:0];
	assign pixel_index   = out_res.idx;
	assign point_range   = out_res.range;
	assign last_of_cloud = out_res.eoc;

endmodule
